// File: src/wlp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlp_pkg: shared types and codes
// Opcodes, register indexes and the queue entry for the windowed projection.
// ----------------------------------------------------------------------------
package wlp_pkg;

  typedef enum logic [1:0] {
    OP_COEF  = 2'd0,
    OP_FEAT  = 2'd1,
    OP_START = 2'd2,
    OP_NONE  = 2'd3
  } opcode_e;

  localparam logic [0:0] REG_NUM_CEPS     = 1'b0;
  localparam logic [0:0] REG_WINDOW_WIDTH = 1'b1;

  // A request handed from the front to the back: a coefficient write or a
  // projection trigger. Feature elements stay in the front.
  typedef enum logic [0:0] {
    CMD_COEF = 1'b0,
    CMD_PROJ = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [13:0] coef_addr;
    logic [15:0] coef_value;
    logic [3:0]  head;
    logic [5:0]  nc;
    logic [4:0]  ww;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MAC,
    BK_DRAIN,
    BK_OUT
  } back_state_e;

endpackage

// File: src/wlp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlp_front: item classifier
// Tracks vector position and ring head, writes feature elements into the
// window memory and queues coefficient writes and projection requests.
// ----------------------------------------------------------------------------
module wlp_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        opcode_i,
  input  logic [8:0]        coef_row_i,
  input  logic [4:0]        coef_col_i,
  input  logic [15:0]       coef_value_i,
  input  logic [15:0]       feature_value_i,
  input  logic              restart_i,
  input  logic [5:0]        num_ceps_i,
  input  logic [4:0]        win_len_i,
  input  logic              busy_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output wlp_pkg::cmd_t     q_data_o,
  output logic              win_we_o,
  output logic [8:0]        win_addr_o,
  output logic [15:0]       win_data_o
);

  logic [4:0] elem_q, elem_d;
  logic [4:0] seen_q, seen_d;
  logic [3:0] head_q, head_d;
  logic [5:0] nc;
  logic [4:0] ww;
  logic       acc;
  logic [4:0] e_use;
  logic [3:0] h_use;
  logic [4:0] s_use;
  logic [4:0] h_next;
  logic       done;

  always_comb begin
    nc = (num_ceps_i == 6'd0) ? 6'd1 : (num_ceps_i > 6'd32) ? 6'd32 : num_ceps_i;
    ww = (win_len_i == 5'd0) ? 5'd1 :
         (win_len_i > 5'd16) ? 5'd16 : win_len_i;
  end

  // The back reads the window ring while it works, so feature elements wait
  // until it is done; other requests only need room in the queue.
  assign in_stall_o = q_full_i || (busy_i && opcode_i == wlp_pkg::OP_FEAT);
  assign acc = in_valid_i && !in_stall_o;

  always_comb begin
    elem_d = elem_q;
    seen_d = seen_q;
    head_d = head_q;
    q_push_o = 1'b0;
    q_data_o = '0;
    q_data_o.nc = nc;
    q_data_o.ww = ww;
    win_we_o = 1'b0;
    win_addr_o = '0;
    win_data_o = feature_value_i;
    e_use = elem_q;
    h_use = head_q;
    s_use = seen_q;
    h_next = '0;
    done = 1'b0;
    if ({1'b0, head_q} >= ww || {1'b0, elem_q} >= nc) begin
      e_use = '0;
      h_use = '0;
      s_use = '0;
    end
    if (restart_i) begin
      elem_d = '0;
      seen_d = '0;
      head_d = '0;
    end else if (acc) begin
      case (opcode_i)
        wlp_pkg::OP_COEF: begin
          q_push_o = 1'b1;
          q_data_o.cmd = wlp_pkg::CMD_COEF;
          q_data_o.coef_addr = {coef_row_i, coef_col_i};
          q_data_o.coef_value = coef_value_i;
        end
        wlp_pkg::OP_START: begin
          elem_d = '0;
          seen_d = '0;
          head_d = '0;
        end
        wlp_pkg::OP_FEAT: begin
          win_we_o = 1'b1;
          win_addr_o = {h_use, e_use};
          elem_d = e_use + 5'd1;
          head_d = h_use;
          seen_d = s_use;
          if ({1'b0, e_use} + 6'd1 >= nc) begin
            elem_d = '0;
            h_next = {1'b0, h_use} + 5'd1;
            head_d = (h_next >= ww) ? 4'd0 : h_next[3:0];
            if (s_use < ww) seen_d = s_use + 5'd1;
            done = (s_use + 5'd1 >= ww);
            if (done) begin
              q_push_o = 1'b1;
              q_data_o.cmd = wlp_pkg::CMD_PROJ;
              q_data_o.head = (h_next >= ww) ? 4'd0 : h_next[3:0];
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elem_q <= '0;
      seen_q <= '0;
      head_q <= '0;
    end else begin
      elem_q <= elem_d;
      seen_q <= seen_d;
      head_q <= head_d;
    end
  end

endmodule

// File: src/wlp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlp_queue: request queue
// Four-entry queue between the front and back parts.
// ----------------------------------------------------------------------------
module wlp_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  wlp_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output wlp_pkg::cmd_t data_o
);

  wlp_pkg::cmd_t mem_q [4];
  logic [1:0] wp_q, rp_q;
  logic [2:0] cnt_q;

  assign full_o  = (cnt_q == 3'd4);
  assign empty_o = (cnt_q == 3'd0);
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 2'd1;
      if (pop_i) rp_q <= rp_q + 2'd1;
      cnt_q <= cnt_q + {2'd0, push_i} - {2'd0, pop_i};
    end
  end

endmodule

// File: src/wlp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlp_back: projection engine
// Holds the coefficient memory and runs one shared multiply-accumulate over
// the stacked window for each output, then scales and saturates.
// ----------------------------------------------------------------------------
module wlp_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_empty_i,
  input  wlp_pkg::cmd_t q_data_i,
  output logic          q_pop_o,
  output logic [8:0]    win_raddr_o,
  input  logic [15:0]   win_rdata_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [4:0]    out_cep_o,
  output logic [23:0]   out_value_o,
  output logic          out_last_o,
  output logic          busy_o
);

  localparam int unsigned CoefFrac = 14;

  wlp_pkg::back_state_e st_q, st_d;
  logic [15:0] coef_mem [16384];
  logic [15:0] coef_rd_q;
  logic [13:0] coef_raddr;

  logic [4:0] c_q, c_d;
  logic [4:0] e_q, e_d;
  logic [3:0] v_q, v_d;
  logic [3:0] slot_q, slot_d;
  logic [8:0] row_q, row_d;
  logic [3:0] head_q;
  logic [5:0] nc_q;
  logic [4:0] ww_q;
  logic       load;
  logic       last_rd;
  logic       p1_q, p2_q, p1_d;
  logic signed [31:0] prod_q;
  logic signed [47:0] acc_q;
  logic signed [47:0] acc_n;
  logic signed [33:0] shifted;
  logic [23:0] sat;
  logic       ov_q;
  logic [4:0] oc_q;
  logic [23:0] ov_val_q;
  logic       olast_q;

  assign coef_raddr = {row_q, c_q};
  assign win_raddr_o = {slot_q, e_q};
  assign busy_o = (st_q != wlp_pkg::BK_IDLE) || !q_empty_i || ov_q;

  always_ff @(posedge clk_i) begin
    if (load && q_data_i.cmd == wlp_pkg::CMD_COEF)
      coef_mem[q_data_i.coef_addr] <= q_data_i.coef_value;
    coef_rd_q <= coef_mem[coef_raddr];
  end

  // row_q walks the stacked window index v*nc + e one step per product,
  // while the window memory keeps a 32-entry stride per ring slot.
  assign last_rd = ({1'b0, e_q} + 6'd1 >= nc_q) && ({1'b0, v_q} + 5'd1 >= ww_q);

  always_comb begin
    st_d = st_q;
    c_d = c_q; e_d = e_q; v_d = v_q; slot_d = slot_q; row_d = row_q;
    q_pop_o = 1'b0;
    load = 1'b0;
    p1_d = 1'b0;
    case (st_q)
      wlp_pkg::BK_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          load = 1'b1;
          if (q_data_i.cmd == wlp_pkg::CMD_PROJ) begin
            st_d = wlp_pkg::BK_MAC;
            c_d = '0; e_d = '0; v_d = '0; row_d = '0;
            slot_d = q_data_i.head;
          end
        end
      end
      wlp_pkg::BK_MAC: begin
        p1_d = 1'b1;
        row_d = row_q + 9'd1;
        if ({1'b0, e_q} + 6'd1 >= nc_q) begin
          e_d = '0;
          v_d = v_q + 4'd1;
          slot_d = ({1'b0, slot_q} + 5'd1 >= ww_q) ? 4'd0 : slot_q + 4'd1;
        end else begin
          e_d = e_q + 5'd1;
        end
        if (last_rd) st_d = wlp_pkg::BK_DRAIN;
      end
      wlp_pkg::BK_DRAIN: begin
        if (!p1_q && !p2_q) st_d = wlp_pkg::BK_OUT;
      end
      wlp_pkg::BK_OUT: begin
        if (!ov_q || !out_stall_i) begin
          if ({1'b0, c_q} + 6'd1 >= nc_q) begin
            st_d = wlp_pkg::BK_IDLE;
          end else begin
            st_d = wlp_pkg::BK_MAC;
            c_d = c_q + 5'd1; e_d = '0; v_d = '0; row_d = '0; slot_d = head_q;
          end
        end
      end
      default: st_d = wlp_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    acc_n = acc_q + 48'(prod_q);
    shifted = 34'(acc_q >>> CoefFrac);
    if (shifted > 34'sd8388607) sat = 24'h7FFFFF;
    else if (shifted < -34'sd8388608) sat = 24'h800000;
    else sat = shifted[23:0];
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      head_q <= q_data_i.head;
      nc_q <= q_data_i.nc;
      ww_q <= q_data_i.ww;
    end
    prod_q <= $signed(win_rdata_i) * $signed(coef_rd_q);
    if (st_q == wlp_pkg::BK_MAC && row_q == '0) acc_q <= '0;
    else if (p2_q) acc_q <= acc_n;
    if (st_q == wlp_pkg::BK_OUT && (!ov_q || !out_stall_i)) begin
      oc_q <= c_q;
      ov_val_q <= sat;
      olast_q <= ({1'b0, c_q} + 6'd1 >= nc_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= wlp_pkg::BK_IDLE;
      c_q <= '0; e_q <= '0; v_q <= '0; slot_q <= '0; row_q <= '0;
      p1_q <= 1'b0; p2_q <= 1'b0; ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      c_q <= c_d; e_q <= e_d; v_q <= v_d; slot_q <= slot_d; row_q <= row_d;
      p1_q <= p1_d; p2_q <= p1_q;
      if (st_q == wlp_pkg::BK_OUT && (!ov_q || !out_stall_i)) ov_q <= 1'b1;
      else if (!out_stall_i) ov_q <= 1'b0;
    end
  end

  assign out_valid_o = ov_q;
  assign out_cep_o = oc_q;
  assign out_value_o = ov_val_q;
  assign out_last_o = olast_q;

endmodule

// File: src/windowed_lda_projection.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_lda_projection: windowed LDA feature projection
// Streams feature elements into a ring of vectors and projects the stacked
// window through a coefficient matrix with one shared MAC.
// ----------------------------------------------------------------------------
//   channel   handshake           payload
//   in        in_valid/in_stall   opcode, coef_row, coef_col, coef_value,
//                                 feature_value
//   out       out_valid/out_stall out_cep, out_value, out_last
//   cfg       cfg_valid/cfg_ready cfg_index, cfg_data
//
// Coefficient, start and non-final feature requests start no projection.
// For a completing vector the back, for each result, takes one product per cycle
// over the stacked window, drains the product pipeline and then presents the
// result, waiting while the output stalls.
// Feature requests stall while the back is busy; others only on a full queue.
// Reset clears control state; coefficient and window memories are not cleared.
// ----------------------------------------------------------------------------
module windowed_lda_projection (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [8:0]  coef_row_i,
  input  logic [4:0]  coef_col_i,
  input  logic signed [15:0] coef_value_i,
  input  logic signed [15:0] feature_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [4:0]  out_cep_o,
  output logic signed [23:0] out_value_o,
  output logic        out_last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [5:0]  cfg_data_i
);

  logic [5:0] num_ceps_q;
  logic [4:0] win_len_q;
  logic cfg_we;
  logic q_push, q_pop, q_full, q_empty, busy;
  wlp_pkg::cmd_t q_in, q_out;
  logic win_we;
  logic [8:0] win_waddr, win_raddr;
  logic [15:0] win_wdata, win_rdata_q;
  logic [15:0] win_mem [512];

  assign cfg_ready_o = 1'b1;
  assign cfg_we = cfg_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_ceps_q <= 6'd1;
      win_len_q <= 5'd1;
    end else if (cfg_we) begin
      if (cfg_index_i == wlp_pkg::REG_NUM_CEPS) num_ceps_q <= cfg_data_i;
      else win_len_q <= cfg_data_i[4:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (win_we) win_mem[win_waddr] <= win_wdata;
    win_rdata_q <= win_mem[win_raddr];
  end

  wlp_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .opcode_i, .coef_row_i, .coef_col_i,
    .coef_value_i(coef_value_i), .feature_value_i(feature_value_i),
    .restart_i(cfg_we), .num_ceps_i(num_ceps_q), .win_len_i(win_len_q),
    .busy_i(busy),
    .q_full_i(q_full), .q_push_o(q_push), .q_data_o(q_in),
    .win_we_o(win_we), .win_addr_o(win_waddr), .win_data_o(win_wdata)
  );

  wlp_queue u_queue (
    .clk_i, .rst_ni, .push_i(q_push), .data_i(q_in), .full_o(q_full),
    .pop_i(q_pop), .empty_o(q_empty), .data_o(q_out)
  );

  wlp_back u_back (
    .clk_i, .rst_ni, .q_empty_i(q_empty), .q_data_i(q_out), .q_pop_o(q_pop),
    .win_raddr_o(win_raddr), .win_rdata_i(win_rdata_q),
    .out_valid_o, .out_stall_i, .out_cep_o, .out_value_o, .out_last_o,
    .busy_o(busy)
  );

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty) else $error("pop from empty queue");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full) else $error("push into full queue");
  a_out_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> busy) else $error("result shown while idle");

endmodule
